@@ hdl/positional_ordered_list_unit_assert.svh @@
// Assertion macros for the positional ordered list unit checker.
// Expects a clock named clock and a reset named reset in the using scope.
`ifndef POSITIONAL_ORDERED_LIST_UNIT_ASSERT_SVH
`define POSITIONAL_ORDERED_LIST_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define POLU_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define POLU_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/polu_pkg.sv @@
// Package for the positional ordered list unit: sizes, command and status codes,
// and the request and response word types. Depends on nothing.
package polu_pkg;

   // List storage sizes.
   localparam int CAPACITY   = 16;
   localparam int DATA_WIDTH = 32;
   localparam int ADDR_W     = $clog2(CAPACITY);
   localparam int CNT_W      = $clog2(CAPACITY + 1);

   // Fixed field widths of the request and response words.
   localparam int POS_W   = 5;
   localparam int VALUE_W = 32;
   localparam int LEN_W   = 5;

   // Width that holds both a position and a count, plus headroom for +1 and +2.
   localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 2;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_APPEND = 2'd1,
      CMD_DELETE = 2'd2,
      CMD_READ   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      cmd_type              command;
      logic [POS_W-1:0]     position;
      logic [VALUE_W-1:0]   value;
   } req_type;

   typedef struct packed {
      logic [VALUE_W-1:0]   read_value;
      logic [LEN_W-1:0]     length;
      status_type           status;
   } rsp_type;

endpackage

@@ hdl/polu_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module polu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/positional_ordered_list_unit.sv @@
// Top level of the positional ordered list unit: sequencer, count and result register.
// Depends on polu_pkg and polu_ram.
//
// A request word is taken when start is high and busy is low; busy then stays high until
// the response word shows on rsp_data for one cycle with rsp_strobe, and busy falls in that
// same cycle, so the next request can be taken at the edge that ends it. The receiver has no
// way to hold the response back. A rejected command goes from the check state straight
// to the done state; append passes through the load state and read through the read
// state. Insert and delete first move each shifted entry with a read state and then a
// write state, and insert then loads the new word. The entry store has a single read
// and a single write port, so each entry that moves takes one read and one write. The
// store needs no clearing after reset.
module positional_ordered_list_unit
   import polu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EVAL,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_LOAD,
      S_READ,
      S_DONE
   } state_type;

   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    rsp_strobe_ff, rsp_strobe_in;
   rsp_type                 rsp_ff, rsp_in;
   cmd_type                 cmd_ff, cmd_in;
   logic [POS_W-1:0]        pos_ff, pos_in;
   logic [DATA_WIDTH-1:0]   val_ff, val_in;
   status_type              status_ff, status_in;
   logic [ADDR_W-1:0]       dest_ff, dest_in;

   logic                    wr_en;
   logic [ADDR_W-1:0]       wr_addr;
   logic [DATA_WIDTH-1:0]   wr_data;
   logic [ADDR_W-1:0]       rd_addr;
   logic [DATA_WIDTH-1:0]   rd_data;

   logic [CMP_W-1:0]        pos_c;
   logic [CMP_W-1:0]        cnt_c;
   logic [CMP_W-1:0]        dest_c;
   logic                    full;

   // Entry store.
   polu_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (CAPACITY)
   ) u_entries (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Position, count and index brought to one common compare width.
   assign pos_c  = CMP_W'(pos_ff);
   assign cnt_c  = CMP_W'(count_ff);
   assign dest_c = CMP_W'(dest_ff);
   assign full   = (count_ff == CNT_W'(CAPACITY));

   // Sequencer next-state and datapath control.
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      cmd_in        = cmd_ff;
      pos_in        = pos_ff;
      val_in        = val_ff;
      status_in     = status_ff;
      dest_in       = dest_ff;
      wr_en         = 1'b0;
      wr_addr       = dest_ff;
      wr_data       = val_ff;
      rd_addr       = dest_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in    = req_data.command;
               pos_in    = req_data.position;
               val_in    = DATA_WIDTH'(req_data.value);
               status_in = ST_OK;
               state_in  = S_EVAL;
            end
         end

         // Check the command against the current length and pick the first step.
         S_EVAL: begin
            unique case (cmd_ff)
               CMD_INSERT: begin
                  if (pos_c == '0 || pos_c > cnt_c + CMP_W'(1)) begin
                     status_in = ST_RANGE;
                     state_in  = S_DONE;
                  end else if (full) begin
                     status_in = ST_FULL;
                     state_in  = S_DONE;
                  end else begin
                     dest_in = ADDR_W'(count_ff);
                     if (cnt_c + CMP_W'(1) == pos_c) begin
                        state_in = S_LOAD;
                     end else begin
                        state_in = S_SHIFT_RD;
                     end
                  end
               end
               CMD_APPEND: begin
                  if (full) begin
                     status_in = ST_FULL;
                     state_in  = S_DONE;
                  end else begin
                     dest_in  = ADDR_W'(count_ff);
                     state_in = S_LOAD;
                  end
               end
               CMD_DELETE: begin
                  if (pos_c == '0 || pos_c > cnt_c) begin
                     status_in = ST_RANGE;
                     state_in  = S_DONE;
                  end else begin
                     dest_in = ADDR_W'(pos_c - CMP_W'(1));
                     if (pos_c < cnt_c) begin
                        state_in = S_SHIFT_RD;
                     end else begin
                        state_in = S_DONE;
                     end
                  end
               end
               CMD_READ: begin
                  if (pos_c == '0 || pos_c > cnt_c) begin
                     status_in = ST_RANGE;
                     state_in  = S_DONE;
                  end else begin
                     dest_in  = ADDR_W'(pos_c - CMP_W'(1));
                     state_in = S_READ;
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end

         // Fetch the neighbor that moves into the destination slot.
         S_SHIFT_RD: begin
            if (cmd_ff == CMD_INSERT) begin
               rd_addr = dest_ff - ADDR_W'(1);
            end else begin
               rd_addr = dest_ff + ADDR_W'(1);
            end
            state_in = S_SHIFT_WR;
         end

         // Store the fetched word and step the destination index.
         S_SHIFT_WR: begin
            wr_en   = 1'b1;
            wr_data = rd_data;
            if (cmd_ff == CMD_INSERT) begin
               dest_in = dest_ff - ADDR_W'(1);
               if (dest_c == pos_c) begin
                  state_in = S_LOAD;
               end else begin
                  state_in = S_SHIFT_RD;
               end
            end else begin
               dest_in = dest_ff + ADDR_W'(1);
               if (dest_c + CMP_W'(2) < cnt_c) begin
                  state_in = S_SHIFT_RD;
               end else begin
                  state_in = S_DONE;
               end
            end
         end

         // Place the new word in its slot.
         S_LOAD: begin
            wr_en    = 1'b1;
            wr_data  = val_ff;
            state_in = S_DONE;
         end

         // Read address is presented here; data is ready in the next state.
         S_READ: begin
            state_in = S_DONE;
         end

         // Update the length and build the response word.
         S_DONE: begin
            if (status_ff == ST_OK) begin
               if (cmd_ff == CMD_INSERT || cmd_ff == CMD_APPEND) begin
                  count_in = count_ff + CNT_W'(1);
               end else if (cmd_ff == CMD_DELETE) begin
                  count_in = count_ff - CNT_W'(1);
               end
            end
            if (cmd_ff == CMD_READ && status_ff == ST_OK) begin
               rsp_in.read_value = VALUE_W'(rd_data);
            end else begin
               rsp_in.read_value = '0;
            end
            rsp_in.length = LEN_W'(count_in);
            rsp_in.status = status_ff;
            rsp_strobe_in = 1'b1;
            state_in      = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State, count and registered outputs; payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      rsp_ff    <= rsp_in;
      cmd_ff    <= cmd_in;
      pos_ff    <= pos_in;
      val_ff    <= val_in;
      status_ff <= status_in;
      dest_ff   <= dest_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

@@ hdl/polu_checker.sv @@
// Port-level checker for the positional ordered list unit, bound to the top level.
// Depends on polu_pkg and positional_ordered_list_unit_assert.svh.
`include "positional_ordered_list_unit_assert.svh"

module polu_checker
   import polu_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_strobe,
   input rsp_type rsp_data
);

   // An accepted request word keeps the block busy in the next cycle.
   `POLU_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")

   // A response word is a single-cycle pulse, and the block is free while it shows.
   `POLU_ASSERT_NEXT(a_strobe_pulse, rsp_strobe, !rsp_strobe, "response strobe held too long")
   `POLU_ASSERT_NOW(a_strobe_idle, rsp_strobe, !busy, "busy high during response word")

   // A rejected command never returns data, and a full status means a full list.
   `POLU_ASSERT_NOW(a_fail_zero, rsp_strobe && rsp_data.status != ST_OK,
      rsp_data.read_value == '0, "failed command returned data")
   `POLU_ASSERT_NOW(a_full_len, rsp_strobe && rsp_data.status == ST_FULL,
      rsp_data.length == LEN_W'(CAPACITY), "full status with short list")

endmodule

bind positional_ordered_list_unit polu_checker u_polu_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

@@ dv/positional_ordered_list_unit_tb.sv @@
// Self-checking testbench for the positional ordered list unit: directed corner commands,
// then random list traffic under varied sender idling. Depends on polu_pkg and the RTL top.
module positional_ordered_list_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import polu_pkg::*;

   // Cycles without any accepted word or response before the run is declared hung.
   localparam int HANG_LIMIT = 2000;
   // Longest command: insert at the head of a list one short of full.
   localparam int SETTLE_CYCLES = 40;
   localparam int PHASE_WORDS = 440;

   // Mirror of the list contents that predicts every response word.
   class list_mirror;
      logic [VALUE_W-1:0] slots [CAPACITY];
      int fill;
      int errors;
      int peak;
      int taken;
      int per_cmd [4];
      int per_status [3];
      rsp_type due_replies [$];
      req_type due_words [$];

      // Apply one accepted command and queue the response it must produce.
      function void take_command(req_type w);
         rsp_type r;
         int p;
         p = int'(w.position);
         r = '0;
         r.status = ST_OK;
         case (w.command)
            CMD_INSERT: begin
               if (p < 1 || p > fill + 1) begin
                  r.status = ST_RANGE;
               end else if (fill >= CAPACITY) begin
                  r.status = ST_FULL;
               end else begin
                  for (int i = fill; i > p - 1; i--) slots[i] = slots[i-1];
                  slots[p-1] = w.value;
                  fill++;
               end
            end
            CMD_APPEND: begin
               if (fill >= CAPACITY) begin
                  r.status = ST_FULL;
               end else begin
                  slots[fill] = w.value;
                  fill++;
               end
            end
            CMD_DELETE: begin
               if (p < 1 || p > fill) begin
                  r.status = ST_RANGE;
               end else begin
                  for (int i = p - 1; i + 1 < fill; i++) slots[i] = slots[i+1];
                  fill--;
               end
            end
            default: begin
               if (p < 1 || p > fill) r.status = ST_RANGE;
               else r.read_value = slots[p-1];
            end
         endcase
         r.length = LEN_W'(fill);
         taken++;
         per_cmd[w.command]++;
         per_status[r.status]++;
         if (fill > peak) peak = fill;
         due_replies.push_back(r);
         due_words.push_back(w);
      endfunction

      task report(string what);
         errors++;
         if (errors <= 40) $display("mismatch at %0t: %s", $realtime, what);
      endtask

      // Compare one strobed response word with the oldest prediction.
      task check_reply(rsp_type got);
         rsp_type want;
         req_type w;
         if (due_replies.size() == 0) begin
            report($sformatf("response %p with no command outstanding", got));
            return;
         end
         want = due_replies.pop_front();
         w = due_words.pop_front();
         if (got.read_value !== want.read_value)
            report($sformatf("%s pos %0d: read_value %h, want %h", w.command.name(),
                             w.position, got.read_value, want.read_value));
         if (got.length !== want.length)
            report($sformatf("%s pos %0d: length %0d, want %0d", w.command.name(),
                             w.position, got.length, want.length));
         if (got.status !== want.status)
            report($sformatf("%s pos %0d: status %0d, want %0d", w.command.name(),
                             w.position, got.status, want.status));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   req_type req_data = '0;
   logic busy;
   logic rsp_strobe;
   rsp_type rsp_data;

   list_mirror mirror = new();
   bit growing = 1'b1;
   int quiet_cycles = 0;

   positional_ordered_list_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Every strobed response word is checked at the edge that ends its cycle.
   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) mirror.check_reply(rsp_data);
   end

   // Hang detection: no command taken and no response for too long.
   always @(posedge clock) begin
      if (reset || (start && busy === 1'b0) || rsp_strobe === 1'b1) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= HANG_LIMIT) begin
         $display("timeout: no word moved for %0d cycles", HANG_LIMIT);
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic req_type make_word(cmd_type c, int p, logic [VALUE_W-1:0] v);
      req_type w;
      w.command = c;
      w.position = POS_W'(p);
      w.value = v;
      return w;
   endfunction

   // Mostly well-formed commands around the current length, drifting between
   // growing and shrinking phases so the list keeps hitting empty and full.
   function automatic req_type random_word();
      req_type w;
      int n;
      int roll;
      int hi;
      n = mirror.fill;
      if (n >= CAPACITY && $urandom_range(3) == 0) growing = 1'b0;
      else if (n == 0 && $urandom_range(3) == 0) growing = 1'b1;
      else if ($urandom_range(49) == 0) growing = !growing;
      w.value = $urandom();
      case ($urandom_range(7))
         0: w.value = '0;
         1: w.value = '1;
         default: ;
      endcase
      if ($urandom_range(99) < 8) begin
         w.command = cmd_type'($urandom_range(3));
         w.position = POS_W'($urandom_range(31));
         return w;
      end
      roll = $urandom_range(99);
      if (growing)
         w.command = roll < 40 ? CMD_INSERT : roll < 65 ? CMD_APPEND :
                     roll < 80 ? CMD_DELETE : CMD_READ;
      else
         w.command = roll < 15 ? CMD_INSERT : roll < 25 ? CMD_APPEND :
                     roll < 70 ? CMD_DELETE : CMD_READ;
      hi = (w.command == CMD_INSERT) ? n + 1 : (n > 0 ? n : 1);
      case ($urandom_range(9))
         0: w.position = POS_W'(1);
         1: w.position = POS_W'(hi);
         default: w.position = POS_W'($urandom_range(hi, 1));
      endcase
      if (w.command == CMD_APPEND) w.position = POS_W'($urandom_range(31));
      return w;
   endfunction

   // Present one word after random idle cycles and hold it until it is taken.
   task send_word(req_type w, int idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (busy !== 1'b0);
      mirror.take_command(w);
   endtask

   // Hold off the sender until every outstanding response has arrived.
   task drain();
      start <= 1'b0;
      do @(posedge clock); while (mirror.due_replies.size() != 0);
   endtask

   task run_directed();
      // Empty list: reads, deletes and bad inserts are rejected; an insert at the head and an append are taken.
      send_word(make_word(CMD_READ, 1, 32'h0), 0);
      send_word(make_word(CMD_DELETE, 0, 32'h0), 0);
      send_word(make_word(CMD_INSERT, 2, 32'h1111_1111), 0);
      send_word(make_word(CMD_INSERT, 1, 32'hFFFF_FFFF), 0);
      send_word(make_word(CMD_INSERT, 0, 32'h2222_2222), 0);
      send_word(make_word(CMD_APPEND, 0, 32'h0), 0);
      // Insert at the tail and in the middle, then read back the last entry.
      send_word(make_word(CMD_INSERT, 3, 32'hA5A5_A5A5), 0);
      send_word(make_word(CMD_INSERT, 2, 32'h5A5A_5A5A), 0);
      send_word(make_word(CMD_READ, 4, 32'h0), 0);
      // Fill to capacity; append ignores even the widest position.
      for (int i = 0; i < CAPACITY - 4; i++)
         send_word(make_word(CMD_APPEND, (i == 0) ? 31 : i, $urandom()), 0);
      // Full list: the range check wins over the full check.
      send_word(make_word(CMD_INSERT, CAPACITY + 2, 32'h3333_3333), 0);
      send_word(make_word(CMD_INSERT, CAPACITY + 1, 32'h4444_4444), 0);
      send_word(make_word(CMD_INSERT, 1, 32'h5555_5555), 0);
      send_word(make_word(CMD_APPEND, 0, 32'h6666_6666), 0);
      send_word(make_word(CMD_READ, CAPACITY, 32'h0), 0);
      send_word(make_word(CMD_DELETE, CAPACITY, 32'h0), 0);
      send_word(make_word(CMD_DELETE, 1, 32'h0), 0);
      send_word(make_word(CMD_READ, CAPACITY - 1, 32'h0), 0);
      send_word(make_word(CMD_READ, 31, 32'h0), 0);
   endtask

   initial begin
      int idle_pct [3];
      idle_pct = '{38, 65, 0};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      drain();
      // Random traffic in three idling regimes, with occasional full drains.
      for (int ph = 0; ph < 3; ph++) begin
         for (int k = 0; k < PHASE_WORDS; k++) begin
            if ($urandom_range(99) == 0) drain();
            send_word(random_word(), idle_pct[ph]);
         end
         drain();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("covered %0d commands: %0d insert, %0d append, %0d delete, %0d read; peak length %0d",
               mirror.taken, mirror.per_cmd[CMD_INSERT], mirror.per_cmd[CMD_APPEND],
               mirror.per_cmd[CMD_DELETE], mirror.per_cmd[CMD_READ], mirror.peak);
      $display("rejected %0d for position and %0d for a full list; %0d mismatches",
               mirror.per_status[ST_RANGE], mirror.per_status[ST_FULL], mirror.errors);
      if (mirror.errors == 0 && mirror.due_replies.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+hdl
hdl/polu_pkg.sv
hdl/polu_ram.sv
hdl/positional_ordered_list_unit.sv
hdl/polu_checker.sv
dv/positional_ordered_list_unit_tb.sv
